@@ hdl/assert_macros.svh @@
// Assertion macros used by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside of reset.
`define FLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define FLA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FLA_ASSERT(lbl, prop, msg)
`define FLA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/fla_pkg.sv @@
// Shared types and constants of the free list allocator.
// No dependencies; used by every module of the block.
package fla_pkg;

    // Default sizing
    localparam int SEGMENTS_DEF = 16;
    localparam int ALIGN_DEF    = 8;
    localparam int HEADER_DEF   = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int REQ_W    = 16;
    localparam int HND_W    = 4;
    localparam int STAT_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int SZ_W     = 17;
    localparam int LIMIT_W  = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMEM   = 2'd1,
        STAT_BADHND  = 2'd2,
        STAT_DBLFREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_SEARCH,
        S_ALLOC,
        S_FREE_RD,
        S_FREE,
        S_MISC
    } fsm_t;

    // Broadcast control into the free list row
    typedef struct packed {
        logic clear;
        logic remove;
        logic append;
        logic best_fit;
    } cell_ctrl_t;

endpackage

@@ hdl/fla_seg_table.sv @@
// Segment table: base and size of each allocated segment.
// One write port, one registered read port. Uses fla_pkg.
module fla_seg_table #(
    parameter int SEGMENTS = fla_pkg::SEGMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(SEGMENTS)-1:0]   wr_addr,
    input  logic [fla_pkg::SZ_W-1:0]      wr_base,
    input  logic [fla_pkg::SZ_W-1:0]      wr_size,
    input  logic [$clog2(SEGMENTS)-1:0]   rd_addr,
    output logic [fla_pkg::SZ_W-1:0]      rd_base,
    output logic [fla_pkg::SZ_W-1:0]      rd_size
);

    logic [fla_pkg::SZ_W-1:0] base_mem [SEGMENTS];
    logic [fla_pkg::SZ_W-1:0] size_mem [SEGMENTS];
    logic [fla_pkg::SZ_W-1:0] rd_base_reg;
    logic [fla_pkg::SZ_W-1:0] rd_size_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_mem[wr_addr] <= wr_base;
            size_mem[wr_addr] <= wr_size;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_base_reg <= base_mem[rd_addr];
        rd_size_reg <= size_mem[rd_addr];
    end

    assign rd_base = rd_base_reg;
    assign rd_size = rd_size_reg;

endmodule

@@ hdl/fla_cell.sv @@
// One free list entry plus one stage of the search wave.
// Entries shift toward the head on removal. Uses fla_pkg.
module fla_cell #(
    parameter int SEGMENTS = fla_pkg::SEGMENTS_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fla_pkg::cell_ctrl_t                 ctrl,
    input  logic [fla_pkg::SZ_W-1:0]            req_size,
    input  logic [$clog2(SEGMENTS)-1:0]         sel_pos,
    input  logic [$clog2(SEGMENTS+1)-1:0]       list_len,
    // entry written on append
    input  logic [$clog2(SEGMENTS)-1:0]         app_handle,
    input  logic [fla_pkg::SZ_W-1:0]            app_size,
    input  logic [fla_pkg::SZ_W-1:0]            app_base,
    // entry of the next cell toward the tail
    input  logic                                nb_valid,
    input  logic [$clog2(SEGMENTS)-1:0]         nb_handle,
    input  logic [fla_pkg::SZ_W-1:0]            nb_size,
    input  logic [fla_pkg::SZ_W-1:0]            nb_base,
    // search wave from the previous cell
    input  logic                                win_found,
    input  logic [fla_pkg::SZ_W-1:0]            win_size,
    input  logic [$clog2(SEGMENTS)-1:0]         win_pos,
    input  logic [$clog2(SEGMENTS)-1:0]         win_handle,
    input  logic [fla_pkg::SZ_W-1:0]            win_base,
    // own entry
    output logic                                valid,
    output logic [$clog2(SEGMENTS)-1:0]         handle,
    output logic [fla_pkg::SZ_W-1:0]            size,
    output logic [fla_pkg::SZ_W-1:0]            base,
    // search wave to the next cell
    output logic                                wout_found,
    output logic [fla_pkg::SZ_W-1:0]            wout_size,
    output logic [$clog2(SEGMENTS)-1:0]         wout_pos,
    output logic [$clog2(SEGMENTS)-1:0]         wout_handle,
    output logic [fla_pkg::SZ_W-1:0]            wout_base
);

    localparam int HW = $clog2(SEGMENTS);
    localparam int CW = $clog2(SEGMENTS+1);
    localparam logic [HW-1:0] MY_POS = HW'(CELL_IDX);
    localparam logic [CW-1:0] MY_LEN = CW'(CELL_IDX);

    logic                     valid_reg, valid_next;
    logic [HW-1:0]            handle_reg, handle_next;
    logic [fla_pkg::SZ_W-1:0] size_reg, size_next;
    logic [fla_pkg::SZ_W-1:0] base_reg, base_next;

    logic                     wfound_reg, wfound_next;
    logic [fla_pkg::SZ_W-1:0] wsize_reg, wsize_next;
    logic [HW-1:0]            wpos_reg, wpos_next;
    logic [HW-1:0]            whnd_reg, whnd_next;
    logic [fla_pkg::SZ_W-1:0] wbase_reg, wbase_next;

    logic fits;
    logic better;

    // Entry update: clear, shift toward head, or append at list end
    always_comb
    begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        size_next   = size_reg;
        base_next   = base_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.remove && (MY_POS >= sel_pos))
        begin
            valid_next  = nb_valid;
            handle_next = nb_handle;
            size_next   = nb_size;
            base_next   = nb_base;
        end
        else if (ctrl.append && (MY_LEN == list_len))
        begin
            valid_next  = 1'b1;
            handle_next = app_handle;
            size_next   = app_size;
            base_next   = app_base;
        end
    end

    // Search stage: first-fit keeps the earliest hit, best-fit a strictly smaller one
    always_comb
    begin
        fits   = valid_reg && (size_reg >= req_size);
        better = !win_found || (ctrl.best_fit && (size_reg < win_size));
        if (fits && better)
        begin
            wfound_next = 1'b1;
            wsize_next  = size_reg;
            wpos_next   = MY_POS;
            whnd_next   = handle_reg;
            wbase_next  = base_reg;
        end
        else
        begin
            wfound_next = win_found;
            wsize_next  = win_size;
            wpos_next   = win_pos;
            whnd_next   = win_handle;
            wbase_next  = win_base;
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            wfound_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            wfound_reg <= wfound_next;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        size_reg   <= size_next;
        base_reg   <= base_next;
        wsize_reg  <= wsize_next;
        wpos_reg   <= wpos_next;
        whnd_reg   <= whnd_next;
        wbase_reg  <= wbase_next;
    end

    assign valid       = valid_reg;
    assign handle      = handle_reg;
    assign size        = size_reg;
    assign base        = base_reg;
    assign wout_found  = wfound_reg;
    assign wout_size   = wsize_reg;
    assign wout_pos    = wpos_reg;
    assign wout_handle = whnd_reg;
    assign wout_base   = wbase_reg;

endmodule

@@ hdl/free_list_allocator_top.sv @@
// Free list allocator: control, heap bookkeeping and the free list row.
// Depends on fla_pkg, fla_cell, fla_seg_table and assert_macros.svh.
// Allocate: two rounding steps, a search wave through the row of SEGMENTS cells,
//   then a commit; free: a segment table read, then a commit; clear and no-op: a commit.
// One request at a time; the next is taken the cycle after the result registers.
// Reset (rst_n low, async): empty heap and free list, first-fit, limit 65536.
`include "assert_macros.svh"

module free_list_allocator_top #(
    parameter int SEGMENTS     = fla_pkg::SEGMENTS_DEF,
    parameter int ALIGN_BYTES  = fla_pkg::ALIGN_DEF,
    parameter int HEADER_BYTES = fla_pkg::HEADER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fla_pkg::IN_TDATA_W-1:0]     s_tdata,  // request_size, segment_handle
    input  logic [fla_pkg::OP_W-1:0]           s_tuser,  // operation
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fla_pkg::OUT_TDATA_W-1:0]    m_tdata,  // status, data_address,
                                                         // granted_handle, reused
    // configuration
    input  logic                               cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fla_pkg::LIMIT_W-1:0]        cfg_data
);

    localparam int HW          = $clog2(SEGMENTS);
    localparam int CW          = $clog2(SEGMENTS+1);
    localparam int SZ_W        = fla_pkg::SZ_W;
    localparam int HSUM_W      = SZ_W + 2;
    localparam int ROUND_STEPS = 2;
    localparam int STEP_MAX    = (SEGMENTS > ROUND_STEPS) ? SEGMENTS : ROUND_STEPS;
    localparam int STEP_W      = $clog2(STEP_MAX);
    localparam int HC_W        = CW + fla_pkg::HND_W;
    // reciprocal of ALIGN_BYTES, exact for every dividend below 2**SZ_W
    localparam int RCP_SH      = SZ_W + $clog2(ALIGN_BYTES);
    localparam int RCP_W       = SZ_W + 2;
    localparam int PROD_W      = SZ_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_K =
        RCP_W'(((1 << RCP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES);

    // FSM and request registers
    fla_pkg::fsm_t             state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    fla_pkg::op_t              op_reg;
    logic [SZ_W-1:0]           val_reg;
    logic [SZ_W-1:0]           quo_reg;
    logic [SZ_W-1:0]           size_reg, size_next;
    logic [fla_pkg::HND_W-1:0] hnd_reg;

    // Configuration
    logic                        mode_reg;
    logic [fla_pkg::LIMIT_W-1:0] limit_reg;

    // Heap bookkeeping
    logic [SEGMENTS-1:0] busy_reg, busy_next;
    logic [CW-1:0]       seg_count_reg, seg_count_next;
    logic [CW-1:0]       free_len_reg, free_len_next;
    logic [SZ_W-1:0]     heap_top_reg, heap_top_next;

    // Result register
    logic                              out_valid_reg, out_valid_next;
    logic [fla_pkg::OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic accept;
    logic out_free;
    logic commit;

    // Rounding
    logic [PROD_W-1:0] rcp_prod;
    logic [SZ_W-1:0]   quo_calc;

    // Free list row
    fla_pkg::cell_ctrl_t ctrl;
    logic [SEGMENTS-1:0] cell_valid;
    logic [HW-1:0]       cell_hnd  [SEGMENTS];
    logic [SZ_W-1:0]     cell_size [SEGMENTS];
    logic [SZ_W-1:0]     cell_base [SEGMENTS];
    logic [SEGMENTS-1:0] wv_found;
    logic [SZ_W-1:0]     wv_size [SEGMENTS];
    logic [HW-1:0]       wv_pos  [SEGMENTS];
    logic [HW-1:0]       wv_hnd  [SEGMENTS];
    logic [SZ_W-1:0]     wv_base [SEGMENTS];

    // Segment table
    logic            tab_we;
    logic [HW-1:0]   hnd_idx;
    logic [SZ_W-1:0] tab_base;
    logic [SZ_W-1:0] tab_size;

    // Commit helpers
    logic [HSUM_W-1:0]          grow_sum;
    logic                       no_room;
    logic [fla_pkg::ADDR_W-1:0] addr_new;
    logic [fla_pkg::ADDR_W-1:0] addr_reuse;
    logic                       hnd_ok;
    logic                       hnd_busy;
    logic                       free_ok;

    assign s_tready = (state_reg == fla_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = out_free && ((state_reg == fla_pkg::S_ALLOC) ||
                                   (state_reg == fla_pkg::S_FREE)  ||
                                   (state_reg == fla_pkg::S_MISC));

    // Round up to ALIGN_BYTES: quotient by reciprocal multiply, then scale back
    assign rcp_prod = PROD_W'(val_reg) * PROD_W'(RCP_K);
    assign quo_calc = SZ_W'(rcp_prod >> RCP_SH);

    always_comb
    begin
        size_next = size_reg;
        if (state_reg == fla_pkg::S_ROUND && step_reg == STEP_W'(ROUND_STEPS-1))
        begin
            size_next = SZ_W'(quo_reg * SZ_W'(ALIGN_BYTES));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fla_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (fla_pkg::op_t'(s_tuser))
                        fla_pkg::OP_ALLOC: state_next = fla_pkg::S_ROUND;
                        fla_pkg::OP_FREE:  state_next = fla_pkg::S_FREE_RD;
                        default:           state_next = fla_pkg::S_MISC;
                    endcase
                end
            end
            fla_pkg::S_ROUND:
            begin
                if (step_reg == STEP_W'(ROUND_STEPS-1))
                    state_next = fla_pkg::S_SEARCH;
            end
            fla_pkg::S_SEARCH:
            begin
                if (step_reg == STEP_W'(SEGMENTS-1))
                    state_next = fla_pkg::S_ALLOC;
            end
            fla_pkg::S_FREE_RD:
            begin
                state_next = fla_pkg::S_FREE;
            end
            fla_pkg::S_ALLOC, fla_pkg::S_FREE, fla_pkg::S_MISC:
            begin
                if (out_free)
                    state_next = fla_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fla_pkg::S_IDLE;
            end
        endcase
    end

    // Step counter for rounding and the search wave
    always_comb
    begin
        step_next = '0;
        if (state_reg == fla_pkg::S_ROUND && step_reg != STEP_W'(ROUND_STEPS-1))
            step_next = step_reg + 1'b1;
        else if (state_reg == fla_pkg::S_SEARCH)
            step_next = step_reg + 1'b1;
    end

    // Commit helpers
    assign hnd_idx    = HW'(hnd_reg);
    assign grow_sum   = HSUM_W'(heap_top_reg) + HSUM_W'(HEADER_BYTES) + HSUM_W'(size_reg);
    assign no_room    = (seg_count_reg >= CW'(SEGMENTS)) ||
                        (grow_sum > HSUM_W'(limit_reg));
    assign addr_new   = fla_pkg::ADDR_W'(heap_top_reg + SZ_W'(HEADER_BYTES));
    assign addr_reuse = fla_pkg::ADDR_W'(wv_base[SEGMENTS-1] + SZ_W'(HEADER_BYTES));
    assign hnd_ok     = HC_W'(hnd_reg) < HC_W'(seg_count_reg);
    assign hnd_busy   = busy_reg[hnd_idx];
    assign free_ok    = hnd_ok && hnd_busy;

    // Outputs of the FSM: commit actions and result
    always_comb
    begin
        busy_next      = busy_reg;
        seg_count_next = seg_count_reg;
        free_len_next  = free_len_reg;
        heap_top_next  = heap_top_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        tab_we         = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.remove    = 1'b0;
        ctrl.append    = 1'b0;
        ctrl.best_fit  = mode_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            case (state_reg)
                fla_pkg::S_ALLOC:
                begin
                    if (wv_found[SEGMENTS-1])
                    begin
                        // reuse a freed segment
                        ctrl.remove   = 1'b1;
                        free_len_next = free_len_reg - 1'b1;
                        busy_next[wv_hnd[SEGMENTS-1]] = 1'b1;
                        out_data_next = fla_pkg::OUT_TDATA_W'({1'b1,
                            fla_pkg::HND_W'(wv_hnd[SEGMENTS-1]), addr_reuse,
                            fla_pkg::STAT_OK});
                    end
                    else if (no_room)
                    begin
                        out_data_next = fla_pkg::OUT_TDATA_W'(fla_pkg::STAT_NOMEM);
                    end
                    else
                    begin
                        // new segment at heap top
                        tab_we         = 1'b1;
                        busy_next[HW'(seg_count_reg)] = 1'b1;
                        heap_top_next  = SZ_W'(grow_sum);
                        seg_count_next = seg_count_reg + 1'b1;
                        out_data_next  = fla_pkg::OUT_TDATA_W'({1'b0,
                            fla_pkg::HND_W'(seg_count_reg), addr_new,
                            fla_pkg::STAT_OK});
                    end
                end
                fla_pkg::S_FREE:
                begin
                    if (!hnd_ok)
                    begin
                        out_data_next = fla_pkg::OUT_TDATA_W'(fla_pkg::STAT_BADHND);
                    end
                    else if (!hnd_busy)
                    begin
                        out_data_next = fla_pkg::OUT_TDATA_W'(fla_pkg::STAT_DBLFREE);
                    end
                    else
                    begin
                        ctrl.append        = 1'b1;
                        busy_next[hnd_idx] = 1'b0;
                        free_len_next      = free_len_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (op_reg == fla_pkg::OP_CLEAR)
                    begin
                        ctrl.clear     = 1'b1;
                        busy_next      = '0;
                        seg_count_next = '0;
                        free_len_next  = '0;
                        heap_top_next  = '0;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fla_pkg::S_IDLE;
            step_reg      <= '0;
            mode_reg      <= 1'b0;
            limit_reg     <= fla_pkg::LIMIT_RESET;
            busy_reg      <= '0;
            seg_count_reg <= '0;
            free_len_reg  <= '0;
            heap_top_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            seg_count_reg <= seg_count_next;
            free_len_reg  <= free_len_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fla_pkg::CFG_SEARCH_MODE: mode_reg  <= cfg_data[0];
                    fla_pkg::CFG_HEAP_LIMIT:  limit_reg <= cfg_data;
                    default:                  mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    // Request payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        size_reg     <= size_next;
        if (accept)
        begin
            op_reg  <= fla_pkg::op_t'(s_tuser);
            hnd_reg <= s_tdata[fla_pkg::REQ_W +: fla_pkg::HND_W];
            val_reg <= SZ_W'(s_tdata[fla_pkg::REQ_W-1:0]) + SZ_W'(ALIGN_BYTES-1);
        end
        else if (state_reg == fla_pkg::S_ROUND)
        begin
            quo_reg <= quo_calc;
        end
    end

    // Segment table
    fla_seg_table #(
        .SEGMENTS (SEGMENTS)
    ) u_seg_table (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (HW'(seg_count_reg)),
        .wr_base (heap_top_reg),
        .wr_size (size_reg),
        .rd_addr (hnd_idx),
        .rd_base (tab_base),
        .rd_size (tab_size)
    );

    // Free list row, head at cell 0
    for (genvar g = 0; g < SEGMENTS; g++)
    begin : g_cell
        logic            nb_v;
        logic [HW-1:0]   nb_h;
        logic [SZ_W-1:0] nb_s;
        logic [SZ_W-1:0] nb_b;
        logic            wi_f;
        logic [SZ_W-1:0] wi_s;
        logic [HW-1:0]   wi_p;
        logic [HW-1:0]   wi_h;
        logic [SZ_W-1:0] wi_b;

        if (g == SEGMENTS-1)
        begin : g_tail
            assign nb_v = 1'b0;
            assign nb_h = '0;
            assign nb_s = '0;
            assign nb_b = '0;
        end
        else
        begin : g_body
            assign nb_v = cell_valid[g+1];
            assign nb_h = cell_hnd[g+1];
            assign nb_s = cell_size[g+1];
            assign nb_b = cell_base[g+1];
        end

        if (g == 0)
        begin : g_head
            assign wi_f = 1'b0;
            assign wi_s = '0;
            assign wi_p = '0;
            assign wi_h = '0;
            assign wi_b = '0;
        end
        else
        begin : g_link
            assign wi_f = wv_found[g-1];
            assign wi_s = wv_size[g-1];
            assign wi_p = wv_pos[g-1];
            assign wi_h = wv_hnd[g-1];
            assign wi_b = wv_base[g-1];
        end

        fla_cell #(
            .SEGMENTS (SEGMENTS),
            .CELL_IDX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .req_size    (size_reg),
            .sel_pos     (wv_pos[SEGMENTS-1]),
            .list_len    (free_len_reg),
            .app_handle  (hnd_idx),
            .app_size    (tab_size),
            .app_base    (tab_base),
            .nb_valid    (nb_v),
            .nb_handle   (nb_h),
            .nb_size     (nb_s),
            .nb_base     (nb_b),
            .win_found   (wi_f),
            .win_size    (wi_s),
            .win_pos     (wi_p),
            .win_handle  (wi_h),
            .win_base    (wi_b),
            .valid       (cell_valid[g]),
            .handle      (cell_hnd[g]),
            .size        (cell_size[g]),
            .base        (cell_base[g]),
            .wout_found  (wv_found[g]),
            .wout_size   (wv_size[g]),
            .wout_pos    (wv_pos[g]),
            .wout_handle (wv_hnd[g]),
            .wout_base   (wv_base[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `FLA_ASSERT(a_list_le_count, free_len_reg <= seg_count_reg, "free list longer than table")
    `FLA_ASSERT(a_list_cells, $countones(cell_valid) == int'(free_len_reg), "row fill != list length")
    `FLA_ASSERT(a_busy_balance, $countones(busy_reg) + int'(free_len_reg) == int'(seg_count_reg), "busy plus free != segments")
    `FLA_ASSERT_NEXT(a_out_source, !out_valid_reg && !commit, !out_valid_reg, "result without a finished request")

endmodule
